[hw/rtl/rgb565_png_up_filter_macros.svh]
// Assertion macros of the checker file of the RGB565 PNG Up filter.
`ifndef RGB565_PNG_UP_FILTER_MACROS_SVH
`define RGB565_PNG_UP_FILTER_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define RPU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb565_png_up_filter: same-cycle property failed");

// Next-cycle implication, ignored while reset is held.
`define RPU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb565_png_up_filter: next-cycle property failed");

`endif

[hw/rtl/rgbup_pkg.sv]
// Shared constants, codes and expansion tables of the RGB565 PNG Up filter.
package rgbup_pkg;

  // PNG filter type byte for the Up filter.
  localparam logic [7:0] FILTER_UP_TAG = 8'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the configuration registers.
  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  // Bit positions in the result tuser.
  localparam int unsigned USER_W       = 3;
  localparam int unsigned USER_TAG_BIT = 0;
  localparam int unsigned USER_EOR_BIT = 1;
  localparam int unsigned USER_EOI_BIT = 2;

  // Byte slots of one pixel's result group, in output order.
  localparam logic [1:0] SLOT_TAG   = 2'd0;
  localparam logic [1:0] SLOT_RED   = 2'd1;
  localparam logic [1:0] SLOT_GREEN = 2'd2;
  localparam logic [1:0] SLOT_BLUE  = 2'd3;

  typedef logic [7:0] lut5_t [32];
  typedef logic [7:0] lut6_t [64];

  // Level * 255 / 31, built at elaboration.
  function automatic lut5_t build_lut5();
    lut5_t lut;
    for (int i = 0; i < 32; i++) begin
      lut[i] = 8'((i * 255) / 31);
    end
    return lut;
  endfunction

  // Level * 255 / 63, built at elaboration.
  function automatic lut6_t build_lut6();
    lut6_t lut;
    for (int i = 0; i < 64; i++) begin
      lut[i] = 8'((i * 255) / 63);
    end
    return lut;
  endfunction

  localparam lut5_t EXPAND5 = build_lut5();
  localparam lut6_t EXPAND6 = build_lut6();

endpackage

[hw/rtl/rgb565_png_up_filter.sv]
// Top level of the RGB565 to RGB888 converter with the PNG Up filter.
//
// Takes one RGB565 pixel per input transaction in raster order and emits the
// PNG Up-filtered RGB888 bytes, one byte per output transaction: a filter tag
// byte of 2 opens every row, then red, green and blue. A pixel that opens a
// row emits four bytes and any other pixel three; the output serializer, one
// byte per cycle while out_tready is high, sets the sustained rate, and a new
// pixel is taken while the previous one is still being emitted. An input pixel
// is registered in the pending stage and then in the serializer stage before
// its first byte is presented. The previous row lives in a line memory of
// MAX_WIDTH words of 24 bits with a registered read port; it needs no
// clearing pass, since the first row of every picture filters against zero.
// Configuration writes are taken at any time but belong between pictures.
module rgb565_png_up_filter #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input: tdata = pixel[15:0].
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,
  // Output: tdata = out_byte[7:0].
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,
  // Output: tuser = is_filter_tag[0], end_of_row[1], end_of_image[2].
  output logic [rgbup_pkg::USER_W-1:0]    out_tuser,
  output logic                            out_tlast,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rgbup_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgbup_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rgbup_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;

  // Configuration registers.
  logic [10:0] width_r;
  logic [15:0] height_r;

  // Picture position counters.
  logic [CW-1:0] col_r;
  logic [15:0]   row_r;
  logic          first_r;

  // Pending stage: pixel waiting for its line memory read.
  logic          p_valid_r;
  logic [23:0]   p_raw_r;
  logic [CW-1:0] p_col_r;
  logic          p_tag_r;
  logic          p_eor_r;
  logic          p_eoi_r;
  logic          p_first_r;
  logic          p_fwd_r;
  logic [23:0]   p_fwd_data_r;
  logic [23:0]   mem_q_r;

  // Serializer stage: filtered bytes of one pixel.
  logic          s_valid_r;
  logic [1:0]    s_idx_r;
  logic [23:0]   s_bytes_r;
  logic          s_eor_r;
  logic          s_eoi_r;

  // Line memory of the previous row, one word per pixel.
  logic [23:0]   line_mem [MAX_WIDTH];

  logic          in_acc;
  logic          out_acc;
  logic          s_done;
  logic          p_move;
  logic [EW-1:0] w_ext;
  logic [EW-1:0] w_eff;
  logic [EW-1:0] col_p1;
  logic [16:0]   h_eff;
  logic [16:0]   row_p1;
  logic          eor;
  logic          eoi;
  logic [23:0]   raw;
  logic [23:0]   above;
  logic [23:0]   filt;

  assign cfg_ready = 1'b1;

  // Handshake and stage movement.
  assign out_acc   = s_valid_r && out_tready;
  assign s_done    = out_acc && (s_idx_r == SLOT_BLUE);
  assign p_move    = p_valid_r && (!s_valid_r || s_done);
  assign in_tready = !p_valid_r || p_move;
  assign in_acc    = in_tvalid && in_tready;

  // Effective picture size and row and picture end detection.
  always_comb begin
    w_ext = EW'(width_r);
    if (width_r == 11'd0) begin
      w_eff = EW'(1);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_eff  = (height_r == 16'd0) ? 17'd1 : {1'b0, height_r};
    col_p1 = EW'(col_r) + EW'(1);
    row_p1 = {1'b0, row_r} + 17'd1;
    eor    = (col_p1 >= w_eff);
    eoi    = eor && (row_p1 >= h_eff);
  end

  // Channel expansion to 8 bits, red in the low byte.
  assign raw = {EXPAND5[in_tdata[4:0]], EXPAND6[in_tdata[10:5]], EXPAND5[in_tdata[15:11]]};

  // Up filter: subtract the byte of the row above, zero on the first row.
  always_comb begin
    if (p_first_r) begin
      above = 24'd0;
    end else if (p_fwd_r) begin
      above = p_fwd_data_r;
    end else begin
      above = mem_q_r;
    end
    filt[7:0]   = p_raw_r[7:0]   - above[7:0];
    filt[15:8]  = p_raw_r[15:8]  - above[15:8];
    filt[23:16] = p_raw_r[23:16] - above[23:16];
  end

  // Control state: configuration, counters and stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_RESET;
      height_r  <= HEIGHT_RESET;
      col_r     <= '0;
      row_r     <= '0;
      first_r   <= 1'b1;
      p_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
      s_idx_r   <= SLOT_TAG;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  width_r  <= cfg_data[10:0];
          REG_IMAGE_HEIGHT: height_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (eoi) begin
          col_r   <= '0;
          row_r   <= '0;
          first_r <= 1'b1;
        end else if (eor) begin
          col_r   <= '0;
          row_r   <= row_r + 16'd1;
          first_r <= 1'b0;
        end else begin
          col_r   <= col_r + CW'(1);
        end
      end
      if (in_acc) begin
        p_valid_r <= 1'b1;
      end else if (p_move) begin
        p_valid_r <= 1'b0;
      end
      if (p_move) begin
        s_valid_r <= 1'b1;
        s_idx_r   <= p_tag_r ? SLOT_TAG : SLOT_RED;
      end else if (s_done) begin
        s_valid_r <= 1'b0;
      end else if (out_acc) begin
        s_idx_r   <= s_idx_r + 2'd1;
      end
    end
  end

  // Pending stage payload and line memory read, with forwarding of the
  // write that leaves in the same cycle at the same column.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_raw_r      <= raw;
      p_col_r      <= col_r;
      p_tag_r      <= (col_r == '0);
      p_eor_r      <= eor;
      p_eoi_r      <= eoi;
      p_first_r    <= first_r;
      p_fwd_r      <= p_move && (p_col_r == col_r);
      p_fwd_data_r <= p_raw_r;
      mem_q_r      <= line_mem[col_r];
    end
  end

  // Line memory write of the unfiltered bytes.
  always_ff @(posedge clk) begin
    if (p_move) begin
      line_mem[p_col_r] <= p_raw_r;
    end
  end

  // Serializer payload.
  always_ff @(posedge clk) begin
    if (p_move) begin
      s_bytes_r <= filt;
      s_eor_r   <= p_eor_r;
      s_eoi_r   <= p_eoi_r;
    end
  end

  // Output byte selection.
  always_comb begin
    case (s_idx_r)
      SLOT_TAG:   out_tdata = FILTER_UP_TAG;
      SLOT_RED:   out_tdata = s_bytes_r[7:0];
      SLOT_GREEN: out_tdata = s_bytes_r[15:8];
      SLOT_BLUE:  out_tdata = s_bytes_r[23:16];
      default:    out_tdata = FILTER_UP_TAG;
    endcase
  end

  assign out_tvalid              = s_valid_r;
  assign out_tlast               = (s_idx_r == SLOT_BLUE);
  assign out_tuser[USER_TAG_BIT] = (s_idx_r == SLOT_TAG);
  assign out_tuser[USER_EOR_BIT] = (s_idx_r == SLOT_BLUE) && s_eor_r;
  assign out_tuser[USER_EOI_BIT] = (s_idx_r == SLOT_BLUE) && s_eoi_r;

endmodule

[hw/rtl/rgb565_png_up_filter_chk.sv]
// Port-level checker of the RGB565 PNG Up filter, bound to the top level.
`include "rgb565_png_up_filter_macros.svh"

module rgb565_png_up_filter_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [7:0]                   out_tdata,
  input logic [rgbup_pkg::USER_W-1:0] out_tuser,
  input logic                         out_tlast
);
  import rgbup_pkg::*;

  // A tag byte carries the Up filter code and never closes a pixel.
  `RPU_ASSERT_NOW(a_tag_byte, clk, rst_n, out_tvalid && out_tuser[USER_TAG_BIT], (out_tdata == FILTER_UP_TAG) && !out_tlast && !out_tuser[USER_EOR_BIT])

  // Picture end is always also a row end, on the last byte of a pixel.
  `RPU_ASSERT_NOW(a_eoi_on_eor, clk, rst_n, out_tvalid && out_tuser[USER_EOI_BIT], out_tuser[USER_EOR_BIT] && out_tlast)

  // A tag transaction is followed directly by the red byte of that pixel.
  `RPU_ASSERT_NEXT(a_tag_then_red, clk, rst_n, out_tvalid && out_tready && out_tuser[USER_TAG_BIT], out_tvalid && !out_tuser[USER_TAG_BIT] && !out_tlast)

  // A stalled result transaction holds its payload.
  `RPU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

endmodule

bind rgb565_png_up_filter rgb565_png_up_filter_chk u_chk (.*);

[test/tb_rgb565_png_up_filter.sv]
// Self-checking testbench for the RGB565 to RGB888 PNG Up filter.
`timescale 1ns / 100ps

module tb_rgb565_png_up_filter;
  import rgbup_pkg::*;

  localparam int MAX_PIXELS = 1024;
  localparam int STALL_LIMIT = 2000;

  // One expected output byte with its side-band flags.
  typedef struct {
    logic [7:0] value;
    logic       tag;
    logic       eor;
    logic       eoi;
    logic       lst;
  } filtered_byte_t;

  // Tracks the block's picture state and holds the bytes it should emit.
  class png_up_scoreboard;
    logic [7:0]     prev_row [3*MAX_PIXELS];
    logic [9:0]     col_cnt;
    logic [15:0]    row_cnt;
    logic           first_row;
    logic [10:0]    width_reg;
    logic [15:0]    height_reg;
    int             written_cols;
    filtered_byte_t pending_bytes [$];
    int             errors;
    int             checked;

    function new();
      col_cnt      = '0;
      row_cnt      = '0;
      first_row    = 1'b1;
      width_reg    = WIDTH_RESET;
      height_reg   = HEIGHT_RESET;
      written_cols = 0;
      errors       = 0;
      checked      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_IMAGE_WIDTH) begin
        width_reg = data[10:0];
      end else if (idx == REG_IMAGE_HEIGHT) begin
        height_reg = data;
      end
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction

    // Below the first row, keep the width within the columns the line store
    // already holds, so that no row reads an entry that was never written.
    function logic [10:0] limit_width(logic [10:0] w);
      int w_eff;
      w_eff = (w == 0) ? 1 : ((w > MAX_PIXELS) ? MAX_PIXELS : int'(w));
      if (!first_row && w_eff > written_cols) begin
        return 11'(written_cols);
      end
      return w;
    endfunction

    // Expand one pixel, filter it against the row above and queue its bytes.
    function void note_pixel(logic [15:0] px);
      int             w;
      int             h;
      int             col;
      int             idx;
      logic [7:0]     level [3];
      logic [7:0]     above;
      logic           eor;
      logic           eoi;
      filtered_byte_t r;

      w = (width_reg == 0) ? 1 : ((width_reg > MAX_PIXELS) ? MAX_PIXELS : int'(width_reg));
      h = (height_reg == 0) ? 1 : int'(height_reg);
      level[0] = 8'((int'(px[15:11]) * 255) / 31);
      level[1] = 8'((int'(px[10:5]) * 255) / 63);
      level[2] = 8'((int'(px[4:0]) * 255) / 31);
      col = int'(col_cnt);
      eor = (col + 1 >= w);
      eoi = eor && (int'(row_cnt) + 1 >= h);

      // A pixel in column zero opens its row with the filter tag.
      if (col == 0) begin
        r = '{value: FILTER_UP_TAG, tag: 1'b1, eor: 1'b0, eoi: 1'b0, lst: 1'b0};
        pending_bytes.push_back(r);
      end
      for (int c = 0; c < 3; c++) begin
        idx = col * 3 + c;
        above = first_row ? 8'd0 : prev_row[idx];
        prev_row[idx] = level[c];
        r.value = level[c] - above;
        r.tag = 1'b0;
        r.eor = (c == 2) && eor;
        r.eoi = (c == 2) && eoi;
        r.lst = (c == 2);
        pending_bytes.push_back(r);
      end
      if (col + 1 > written_cols) begin
        written_cols = col + 1;
      end

      // Advance the column and row position.
      if (eoi) begin
        col_cnt   = '0;
        row_cnt   = '0;
        first_row = 1'b1;
      end else if (eor) begin
        col_cnt   = '0;
        row_cnt   = row_cnt + 16'd1;
        first_row = 1'b0;
      end else begin
        col_cnt = 10'(col + 1);
      end
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    // Compare one output transaction with the oldest expected byte.
    function void check_byte(logic [7:0] data, logic [USER_W-1:0] user, logic lst);
      filtered_byte_t e;
      if (pending_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected output byte, expected none, actual %h user %b last %b",
                 $time, data, user, lst);
        return;
      end
      e = pending_bytes.pop_front();
      checked++;
      compare("out_byte", e.value, data);
      compare("is_filter_tag", 8'(e.tag), 8'(user[USER_TAG_BIT]));
      compare("end_of_row", 8'(e.eor), 8'(user[USER_EOR_BIT]));
      compare("end_of_image", 8'(e.eoi), 8'(user[USER_EOI_BIT]));
      compare("last", 8'(e.lst), 8'(lst));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;
  logic [USER_W-1:0]     out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  png_up_scoreboard sb = new();
  bit src_idle;
  bit sink_idle;
  int stall_left;
  int quiet_cycles;
  int n_pixels;
  int n_settings;

  rgb565_png_up_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // Output ready with random stall bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (sink_idle && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(1, 12);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor every transaction on the three channels.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
      end
      if (in_tvalid && in_tready) begin
        sb.note_pixel(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        sb.check_byte(out_tdata, out_tuser, out_tlast);
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_pixel(input logic [15:0] px);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_pixels++;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write the size registers while the block is idle.
  task automatic set_size(input logic [15:0] w_data, input logic [15:0] h_data,
                          input bit do_w, input bit do_h);
    if (do_w) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_IMAGE_WIDTH;
      cfg_data  <= w_data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    if (do_h) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_IMAGE_HEIGHT;
      cfg_data  <= h_data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Stop sending and wait for every queued byte.
  task automatic end_burst();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait_drained();
  endtask

  function automatic logic [15:0] random_pixel();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] directed_px [6];
    logic [10:0] w;
    logic [15:0] h;
    int          burst;
    int          rnd_pixels;
    int          phase;
    bit          pause_now;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data  = '0;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    n_pixels  = 0;
    n_settings = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero width and height both act as one: every pixel is a whole picture.
    set_size(16'd0, 16'd0, 1'b1, 1'b1);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'hF800);
    send_pixel(16'h07E0);
    send_pixel(16'h001F);
    end_burst();

    // A 3x2 picture with full-scale steps between rows, so the subtraction wraps.
    directed_px = '{16'hFFFF, 16'h0000, 16'hF81F, 16'h0000, 16'hFFFF, 16'h07E0};
    set_size(16'd3, 16'd2, 1'b1, 1'b1);
    foreach (directed_px[i]) send_pixel(directed_px[i]);
    for (int i = 0; i < 4; i++) send_pixel(random_pixel());
    end_burst();

    // Shrink the size mid-picture: the column and row are already past the new end.
    set_size(16'd1, 16'd1, 1'b1, 1'b1);
    send_pixel(16'h5A5A);
    end_burst();

    // An oversized width clamps to the full line; the first row starts at full rate.
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    set_size(16'hFFFF, 16'd1, 1'b1, 1'b1);
    for (int i = 0; i < 16; i++) send_pixel(random_pixel());
    end_burst();

    // Random sizes, with pictures that carry on across size changes.
    rnd_pixels = 0;
    phase = 0;
    while (rnd_pixels < 64) begin
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       w = 11'd1;
        1:       w = 11'd1024;
        2:       w = 11'($urandom_range(1025, 2047));
        3:       w = 11'd0;
        default: w = 11'($urandom_range(2, 8));
      endcase
      w = sb.limit_width(w);
      case ($urandom_range(0, 7))
        0:       h = 16'hFFFF;
        1:       h = 16'd0;
        default: h = 16'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 5))
        0:       set_size({5'($urandom), w}, h, 1'b1, 1'b0);
        1:       set_size({5'($urandom), w}, h, 1'b0, 1'b1);
        default: set_size({5'($urandom), w}, h, 1'b1, 1'b1);
      endcase
      // Mostly whole small pictures, otherwise arbitrary bursts.
      if (w >= 2 && w <= 8 && h >= 1 && h <= 4 && $urandom_range(0, 2) != 0) begin
        burst = int'(w) * int'(h);
      end else begin
        burst = $urandom_range(4, 20);
      end
      pause_now = (phase == 0) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < burst; i++) begin
        if (pause_now && i == burst / 2) begin
          end_burst();
        end
        send_pixel(random_pixel());
      end
      rnd_pixels += burst;
      phase++;
      end_burst();
    end

    // Final stretch at full rate on both sides.
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    set_size({5'd0, sb.limit_width(11'd5)}, 16'd3, 1'b1, 1'b1);
    for (int i = 0; i < 24; i++) send_pixel(random_pixel());
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait_drained();
    repeat (20) @(posedge clk);

    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected bytes never arrived", $time, sb.pending());
    end
    $display("Sent %0d pixels over %0d size settings (zero, clamped and small widths,",
             n_pixels, n_settings);
    $display("mid-picture size changes, random stalls); %0d output bytes checked.", sb.checked);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/rgbup_pkg.sv
hw/rtl/rgb565_png_up_filter.sv
hw/rtl/rgb565_png_up_filter_chk.sv
test/tb_rgb565_png_up_filter.sv
